// ===== rtl/swm_pkg.sv =====
// Shared constants, types and helper functions of the sliding window median filter.
package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_W        = 7;
    localparam int AGE_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int K_RESET      = 3;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic [AGE_W-1:0]        age;
    } t_entry;

    // What a cell shows its right-hand neighbor.
    typedef struct packed {
        t_entry entry;
        logic   le;
        logic   aft;
    } t_link;

    // Broadcast control for the whole cell row.
    typedef struct packed {
        logic                    upd;
        logic                    ins;
        logic                    del_en;
        logic [SAMPLE_WIDTH-1:0] key;
        logic [AGE_W-1:0]        del_age;
    } t_cell_ctrl;

    // Maps a written window length onto the supported range.
    function automatic logic [CNT_W-1:0] f_eff_k(input logic [CFG_W-1:0] ws);
        int unsigned w;
        w = ws;
        if (w == 0) begin
            w = 1;
        end else if (w > WINDOW_MAX) begin
            w = WINDOW_MAX;
        end
        return CNT_W'(w);
    endfunction

endpackage

// ===== rtl/swm_cell.sv =====
// One cell of the sorted window row: holds one entry and shifts with its neighbors.
module swm_cell import swm_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_valid,
    input  logic       i_aft,
    input  t_link      i_left,
    input  t_entry     i_right_b,
    output t_link      o_link,
    output t_entry     o_b,
    output logic       o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_le;
    t_entry w_b;
    logic   w_b_aft;

    assign w_le = i_valid && ($signed(r_entry.value) <= $signed(i_ctrl.key));

    // The row after insertion: this cell keeps its entry, takes the new sample,
    // or takes its left neighbor's entry. Aging rides along with insertion.
    always_comb begin
        if (!i_ctrl.ins) begin
            w_b     = r_entry;
            w_b_aft = i_aft;
        end else if (w_le) begin
            w_b.value = r_entry.value;
            w_b.age   = r_entry.age + AGE_W'(1);
            w_b_aft   = i_aft;
        end else if (i_left.le) begin
            w_b.value = i_ctrl.key;
            w_b.age   = '0;
            w_b_aft   = i_left.aft;
        end else begin
            w_b.value = i_left.entry.value;
            w_b.age   = i_left.entry.age + AGE_W'(1);
            w_b_aft   = i_left.aft;
        end
    end

    // At or after the removed entry, the row closes the gap from the right.
    always_comb begin
        if (i_ctrl.upd) begin
            n_entry = w_b_aft ? i_right_b : w_b;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link = '{entry: r_entry, le: w_le, aft: i_aft};
    assign o_b    = w_b;
    assign o_hit  = i_ctrl.del_en && i_valid && (r_entry.age == i_ctrl.del_age);

endmodule

// ===== rtl/sliding_window_median.sv =====
// Top level of the sliding window median filter: cell row, control and output buffer.
//
// Samples enter on the s_axis channel, one request per signed sample, and
// results leave on the m_axis channel. Once the window holds window_size
// samples, every sample yields the lower median of the last window_size
// samples; earlier samples yield nothing. The window length is written on
// i_cfg_we / i_cfg_wdata while the block is idle; 0 acts as 1 and values
// above 64 act as 64.
// One sample is taken per clock while s_axis_tready is high. The window lives in a row
// of 64 cells that insert the new sample and drop the oldest one in the same cycle,
// so the median is ready in the request cycle and is registered into the output
// buffer that drives m_axis. After the window length is made shorter, the row drops
// its oldest entries one per cycle, with s_axis_tready low, until it holds one
// fewer than the new length. Reset empties the window and sets the length to 3.
// Results wait in a two-entry output buffer; when the receiver stalls and the
// buffer is full, s_axis_tready goes low until a result is taken.
module sliding_window_median import swm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [31:0] sample
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_WIDTH-1:0] m_axis_tdata    // [31:0] median
);

    localparam logic [1:0] QCNT_EMPTY = 2'd0;
    localparam logic [1:0] QCNT_ONE   = 2'd1;
    localparam logic [1:0] QCNT_FULL  = 2'd2;

    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_fill;
    logic [CNT_W-1:0]        n_fill;
    logic [SAMPLE_WIDTH-1:0] r_q0;
    logic [SAMPLE_WIDTH-1:0] r_q1;
    logic [SAMPLE_WIDTH-1:0] n_q0;
    logic [SAMPLE_WIDTH-1:0] n_q1;
    logic [1:0]              r_qcnt;
    logic [1:0]              n_qcnt;

    t_cell_ctrl              w_ctrl;
    t_link                   w_link [WINDOW_MAX];
    t_entry                  w_b    [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]   w_hit;
    logic [WINDOW_MAX-1:0]   w_aft;
    logic [WINDOW_MAX-1:0]   w_valid;
    logic                    w_trim;
    logic                    w_in_acc;
    logic                    w_k_one;
    logic                    w_full;
    logic                    w_produce;
    logic                    w_push;
    logic                    w_pop;
    logic [AGE_W-1:0]        w_rank;
    logic [SAMPLE_WIDTH-1:0] w_med;

    assign w_trim    = r_fill >= r_k;
    assign s_axis_tready = !w_trim && (r_qcnt != QCNT_FULL);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_k_one   = r_k == CNT_W'(1);
    assign w_full    = r_fill == (r_k - CNT_W'(1));
    assign w_produce = w_in_acc && w_full;

    always_comb begin
        w_ctrl.upd     = w_trim || (w_in_acc && !w_k_one);
        w_ctrl.ins     = !w_trim;
        w_ctrl.del_en  = w_trim || (w_in_acc && w_full && !w_k_one);
        w_ctrl.key     = s_axis_tdata;
        w_ctrl.del_age = AGE_W'(r_fill - CNT_W'(1));
    end

    // Everything at or after the removed entry moves one place to the left.
    assign w_aft = ~(w_hit - WINDOW_MAX'(1));

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            t_link  w_left;
            t_entry w_right_b;

            assign w_valid[gi] = CNT_W'(gi) < r_fill;

            if (gi == 0) begin : g_head
                assign w_left = '{entry: '0, le: 1'b1, aft: 1'b0};
            end else begin : g_body
                assign w_left = w_link[gi-1];
            end

            if (gi == WINDOW_MAX - 1) begin : g_tail
                assign w_right_b = '0;
            end else begin : g_inner
                assign w_right_b = w_b[gi+1];
            end

            swm_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (w_ctrl),
                .i_valid   (w_valid[gi]),
                .i_aft     (w_aft[gi]),
                .i_left    (w_left),
                .i_right_b (w_right_b),
                .o_link    (w_link[gi]),
                .o_b       (w_b[gi]),
                .o_hit     (w_hit[gi])
            );
        end
    endgenerate

    // The lower median sits at rank (k-1)/2 of the row once the sample is in.
    assign w_rank = AGE_W'((r_k - CNT_W'(1)) >> 1);
    assign w_med  = w_k_one ? s_axis_tdata : w_b[w_rank].value;

    always_comb begin
        if (w_trim) begin
            n_fill = r_fill - CNT_W'(1);
        end else if (w_ctrl.upd) begin
            n_fill = w_ctrl.del_en ? r_fill : r_fill + CNT_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    assign w_push = w_produce;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_q0   = r_q0;
        n_q1   = r_q1;
        n_qcnt = r_qcnt;
        case ({w_push, w_pop})
            2'b10: begin
                if (r_qcnt == QCNT_EMPTY) begin
                    n_q0 = w_med;
                end else begin
                    n_q1 = w_med;
                end
                n_qcnt = r_qcnt + 2'd1;
            end
            2'b01: begin
                n_q0   = r_q1;
                n_qcnt = r_qcnt - 2'd1;
            end
            2'b11: begin
                if (r_qcnt == QCNT_ONE) begin
                    n_q0 = w_med;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = w_med;
                end
            end
            default: begin
                n_qcnt = r_qcnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= CNT_W'(K_RESET);
            r_fill <= '0;
            r_qcnt <= QCNT_EMPTY;
        end else begin
            if (i_cfg_we) begin
                r_k <= f_eff_k(i_cfg_wdata);
            end
            r_fill <= n_fill;
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign m_axis_tvalid = r_qcnt != QCNT_EMPTY;
    assign m_axis_tdata  = r_q0;

    // A sample is only taken once the window is trimmed to below its length.
    a_accept_trimmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (r_fill < r_k))
        else $error("sample taken while window is over length");

    // Ages in the row are distinct and complete, so a removal finds exactly one entry.
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.del_en |-> $onehot(w_hit))
        else $error("removal does not find exactly one oldest entry");

    a_no_stray_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ctrl.del_en |-> (w_hit == '0))
        else $error("entry marked for removal without a removal");

    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce |=> m_axis_tvalid)
        else $error("result missing from output buffer");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(WINDOW_MAX))
        else $error("window fill count out of range");

endmodule
